// File: hdl/jse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character constants and escape helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  // character codes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_HEX_ALPHA = 8'h57;  // 'a' minus ten
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;

  // escape kinds of the string byte in one item
  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SHORT   = 2'd1,
    KIND_UNICODE = 2'd2
  } kind_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic       sos;
    logic       eos;
    logic       valid;
    kind_t      kind;
    logic [7:0] ch;     // raw byte, or the short code letter for KIND_SHORT
    logic [3:0] count;  // results this item causes, 0..8
  } desc_t;

  // bytes taken by the escaped form of the string byte
  function automatic logic [2:0] kind_len(input kind_t kind);
    logic [2:0] len;
    case (kind)
      KIND_SHORT:   len = 3'd2;
      KIND_UNICODE: len = 3'd6;
      default:      len = 3'd1;
    endcase
    return len;
  endfunction

  // lower-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) d = CH_ZERO + {4'd0, nib};
    else             d = CH_HEX_ALPHA + {4'd0, nib};
    return d;
  endfunction

  // byte at position q of the escaped form
  function automatic logic [7:0] seq_byte(input kind_t kind, input logic [7:0] ch,
                                          input logic [2:0] q);
    logic [7:0] b;
    case (kind)
      KIND_SHORT: b = (q == 3'd0) ? CH_BACKSLASH : ch;
      KIND_UNICODE: begin
        case (q)
          3'd0:    b = CH_BACKSLASH;
          3'd1:    b = CH_U;
          3'd4:    b = hex_digit(ch[7:4]);
          3'd5:    b = hex_digit(ch[3:0]);
          default: b = CH_ZERO;
        endcase
      end
      default: b = ch;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/jse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_front
// Classifies an incoming transaction into an escape descriptor.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
  input  logic [7:0] char_in,
  input  logic       char_valid,
  input  logic       start_of_string,
  input  logic       end_of_string,
  output desc_t      desc,
  output logic       has_results
);

  kind_t      kind;
  logic [7:0] code;

  // escape class of the byte
  always_comb begin
    kind = KIND_PLAIN;
    code = char_in;
    case (char_in)
      8'h22: begin kind = KIND_SHORT; code = CH_QUOTE; end
      8'h5C: begin kind = KIND_SHORT; code = CH_BACKSLASH; end
      8'h08: begin kind = KIND_SHORT; code = 8'h62; end  // b
      8'h0C: begin kind = KIND_SHORT; code = 8'h66; end  // f
      8'h0A: begin kind = KIND_SHORT; code = 8'h6E; end  // n
      8'h0D: begin kind = KIND_SHORT; code = 8'h72; end  // r
      8'h09: begin kind = KIND_SHORT; code = 8'h74; end  // t
      default: begin
        if (char_in < CTRL_LIMIT) kind = KIND_UNICODE;
      end
    endcase
  end

  // descriptor with its result count
  always_comb begin
    desc.sos   = start_of_string;
    desc.eos   = end_of_string;
    desc.valid = char_valid;
    desc.kind  = kind;
    desc.ch    = code;
    desc.count = {3'd0, start_of_string} + {3'd0, end_of_string}
               + (char_valid ? {1'b0, kind_len(kind)} : 4'd0);
  end

  // an item with no byte and no marker produces nothing
  assign has_results = char_valid | start_of_string | end_of_string;

endmodule

// File: hdl/jse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue
// Small descriptor queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module jse_queue import jse_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  desc_t wr_data,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  full,
  output logic  not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  assign rd_data   = mem[rd_ptr];
  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);

endmodule

// File: hdl/jse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_back
// Walks the head descriptor into the output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_t      desc,
  input  logic       desc_ready,
  output logic       desc_done,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic [2:0] idx;
  logic       out_valid;
  logic [7:0] obyte;
  logic       olast;
  logic       advance;
  logic       is_last;
  logic [2:0] q;
  logic [7:0] cur_byte;

  // output register free or drained this cycle
  assign advance = desc_ready && (!out_valid || pop);
  assign is_last = ({1'b0, idx} == desc.count - 4'd1);
  assign desc_done = advance && is_last;

  // select byte at the current position
  always_comb begin
    q = idx - {2'd0, desc.sos};
    if (desc.sos && idx == 3'd0)                  cur_byte = CH_QUOTE;
    else if (desc.valid && q < kind_len(desc.kind)) cur_byte = seq_byte(desc.kind, desc.ch, q);
    else                                          cur_byte = CH_QUOTE;
  end

  // position counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      obyte <= cur_byte;
      olast <= is_last;
    end
  end

  assign empty    = !out_valid;
  assign out_byte = obyte;
  assign run_last = olast;

endmodule

// File: hdl/json_string_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper
// Path: an accepted item is written into the descriptor queue; its first result
//   passes through the output register to the ports. Throughput: one result
//   byte per cycle while pop drains the output; an item holds the sequencer
//   until all its results are out, so plain bytes stream at one per cycle.
// Reset: synchronous, clears the descriptor queue and the output register.
// ----------------------------------------------------------------------------
module json_string_escaper import jse_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       char_valid,
  input  logic       start_of_string,
  input  logic       end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_last
);

  desc_t front_desc;
  desc_t head_desc;
  logic  has_results;
  logic  q_full;
  logic  q_not_empty;
  logic  q_rd;

  // classify incoming transaction
  jse_front u_front (
    .char_in         (char_in),
    .char_valid      (char_valid),
    .start_of_string (start_of_string),
    .end_of_string   (end_of_string),
    .desc            (front_desc),
    .has_results     (has_results)
  );

  // descriptor queue
  jse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push && !q_full && has_results),
    .wr_data   (front_desc),
    .rd_en     (q_rd),
    .rd_data   (head_desc),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // output sequencer
  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (head_desc),
    .desc_ready (q_not_empty),
    .desc_done  (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .run_last   (run_last)
  );

  assign full = q_full;

endmodule

// File: hdl/jse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_checker
// Port-level assertions for the JSON string escaper.
// ----------------------------------------------------------------------------
module jse_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       run_last
);

  // reset leaves no pending result
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // reset leaves room for input
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("queue full after reset");

  // the next byte of a sequence follows without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !run_last) |=> !empty)
    else $error("gap inside an escape run");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)))
    else $error("stalled result changed");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .run_last (run_last)
);

// File: tb/tb_json_string_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking bench for the JSON string escaper. A directed table covers
// empty items, empty strings, zero and control bytes, the short escapes and
// the byte extremes. Random framed strings and noise items follow. Every result
// transaction is compared against an in-bench escape predictor or a row's
// hand-written expectation, with bursty push traffic and a patterned pop stall on the result side.
// ----------------------------------------------------------------------------
module tb_json_string_escaper;
  import jse_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 76;
  localparam int SETTLE_CYCLES = 20;
  localparam int N_DIRECTED   = 24;

  // control bytes with a short escape form
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_TAB = 8'h09;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_CR  = 8'h0D;

  // one input item, with an optional hand-written expectation
  typedef struct packed {
    logic [7:0]  ch;
    logic        valid;
    logic        sos;
    logic        eos;
    logic        typed;      // use exp_text instead of the predictor
    logic [3:0]  exp_len;
    logic [63:0] exp_text;   // first byte in the most significant used byte
  } stim_row_t;

  // one expected output byte
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_in = 8'h00;
  logic       char_valid = 1'b0;
  logic       start_of_string = 1'b0;
  logic       end_of_string = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  esc_byte_t escaped_q[$];
  esc_byte_t head;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  logic [7:0] stall_phase = 8'h00;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0},                   // empty item
    '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 4'd2, "\"\""},                  // empty string
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 4'd8, "\"\\u0000\""},           // zero byte, framed
    '{8'h1F, 1'b1, 1'b0, 1'b0, 1'b1, 4'd6, "\\u001f"},               // top control byte
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 4'd1, 64'hFF},                  // top byte passes
    '{8'h22, 1'b1, 1'b1, 1'b0, 1'b1, 4'd3, "\"\\\""},                // quote after open
    '{8'h5C, 1'b1, 1'b0, 1'b1, 1'b1, 4'd3, "\\\\\""},                // backslash, close
    '{CTRL_BS,  1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{CTRL_FF,  1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{CTRL_LF,  1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{CTRL_CR,  1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{CTRL_TAB, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h20, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h41, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h7A, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0},
    '{8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 64'h0},                   // open marker only
    '{8'h5A, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0},                   // close marker only
    '{8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h10, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h0B, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h1B, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0, 64'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0}                    // ignored byte
  };

  json_string_escaper dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .char_in         (char_in),
    .char_valid      (char_valid),
    .start_of_string (start_of_string),
    .end_of_string   (end_of_string),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .run_last        (run_last)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // lower-case hex digit
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) d = CH_ZERO + {4'd0, nib};
    else             d = "a" + {4'd0, nib} - 8'd10;
    return d;
  endfunction

  // escaped bytes of one item, queued with the last-byte flag
  function automatic void predict_escape(input stim_row_t row);
    logic [7:0] seq[$];
    logic [7:0] short_code;
    esc_byte_t  e;
    if (row.sos) seq.push_back(CH_QUOTE);
    if (row.valid) begin
      case (row.ch)
        CH_QUOTE:     short_code = CH_QUOTE;
        CH_BACKSLASH: short_code = CH_BACKSLASH;
        CTRL_BS:      short_code = "b";
        CTRL_FF:      short_code = "f";
        CTRL_LF:      short_code = "n";
        CTRL_CR:      short_code = "r";
        CTRL_TAB:     short_code = "t";
        default:      short_code = 8'h00;
      endcase
      if (short_code != 8'h00) begin
        seq.push_back(CH_BACKSLASH);
        seq.push_back(short_code);
      end else if (row.ch < CTRL_LIMIT) begin
        seq.push_back(CH_BACKSLASH);
        seq.push_back(CH_U);
        seq.push_back(CH_ZERO);
        seq.push_back(CH_ZERO);
        seq.push_back(nibble_char(row.ch[7:4]));
        seq.push_back(nibble_char(row.ch[3:0]));
      end else begin
        seq.push_back(row.ch);
      end
    end
    if (row.eos) seq.push_back(CH_QUOTE);
    foreach (seq[i]) begin
      e.ch   = seq[i];
      e.last = (i == seq.size() - 1);
      escaped_q.push_back(e);
    end
  endfunction

  // byte mix weighted toward escapes
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(6))
          0:       c = CH_QUOTE;
          1:       c = CH_BACKSLASH;
          2:       c = CTRL_BS;
          3:       c = CTRL_FF;
          4:       c = CTRL_LF;
          5:       c = CTRL_CR;
          default: c = CTRL_TAB;
        endcase
      end
      1:       c = 8'($urandom_range(31));
      2:       c = 8'($urandom_range(126, 32));
      default: c = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  // push one transaction, with bursty gaps ahead of it
  task automatic send_item(input stim_row_t row);
    int        gap;
    esc_byte_t e;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      burst_left = $urandom_range(16, 1);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push            <= 1'b1;
    char_in         <= row.ch;
    char_valid      <= row.valid;
    start_of_string <= row.sos;
    end_of_string   <= row.eos;
    @(posedge clk);
    while (full) @(posedge clk);
    // accepted at this edge
    if (row.typed) begin
      for (int i = 0; i < int'(row.exp_len); i++) begin
        e.ch   = row.exp_text[8 * (int'(row.exp_len) - 1 - i) +: 8];
        e.last = (i == int'(row.exp_len) - 1);
        escaped_q.push_back(e);
      end
    end else begin
      predict_escape(row);
    end
  endtask

  // hold off pushing until every expected byte has come out
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (escaped_q.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    stim_row_t row;
    int        rand_count;
    int        str_len;
    bit        paused;
    bit        broken;
    rand_count = 0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < N_DIRECTED; r++) send_item(directed_rows[r]);
    drain_results();

    // random strings and noise
    while (rand_count < RANDOM_ITEMS) begin
      if (!paused && rand_count >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(4) == 0) begin
        row       = '0;
        row.ch    = 8'($urandom_range(255));
        row.valid = 1'($urandom_range(1));
        row.sos   = 1'($urandom_range(1));
        row.eos   = 1'($urandom_range(1));
        send_item(row);
        if (row.valid || row.sos || row.eos) rand_count++;
      end else begin
        str_len = $urandom_range(8);
        broken  = ($urandom_range(7) == 0);
        if (str_len == 0) begin
          row     = '0;
          row.ch  = 8'($urandom_range(255));
          row.sos = 1'b1;
          row.eos = 1'b1;
          send_item(row);
          rand_count++;
        end else begin
          for (int k = 0; k < str_len; k++) begin
            row       = '0;
            row.ch    = pick_char();
            row.valid = 1'b1;
            row.sos   = (k == 0);
            row.eos   = (k == str_len - 1) && !broken;
            send_item(row);
            rand_count++;
          end
        end
      end
    end

    // wait out the tail, then report
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: patterned pop stall and byte check
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (escaped_q.size() == 0) begin
          $error("unexpected transaction: out_byte %h run_last %b", out_byte, run_last);
          fail_count++;
        end else begin
          head = escaped_q.pop_front();
          if (out_byte !== head.ch) begin
            $error("out_byte mismatch: expected %h, actual %h", head.ch, out_byte);
            fail_count++;
          end
          if (run_last !== head.last) begin
            $error("run_last mismatch: expected %b, actual %b", head.last, run_last);
            fail_count++;
          end
        end
      end
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= 1'($urandom_range(1));
        2'd2:    pop <= ($urandom_range(3) == 0);
        default: pop <= (stall_phase % 3 != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// File: sim.f
hdl/jse_pkg.sv
hdl/jse_front.sv
hdl/jse_queue.sv
hdl/jse_back.sv
hdl/json_string_escaper.sv
hdl/jse_checker.sv
tb/tb_json_string_escaper.sv
